/* rtl/core/gsps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gsps_pkg;

   // Field widths
   localparam int LEVEL_W   = 7;
   localparam int SPEED_W   = 8;
   localparam int DGAIN_W   = 16;
   localparam int STEER_W   = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // Register map
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_LEVEL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DERIV_GAIN   = 1'd1;
   localparam logic [LEVEL_W-1:0]     TARGET_RESET     = 7'd50;

   // Gain schedule
   localparam int GAIN_SETS_DEF = 5;
   localparam int ROM_DEPTH     = 8;
   localparam int KEY_W         = 3;
   localparam int KEY_BASE      = 60;
   localparam int KEY_STEP      = 10;
   localparam int GAIN_W        = 14;

   // Fixed-point widths
   localparam int INTEG_W = 32;
   localparam int ERR_W   = 9;
   localparam int DIF_W   = 17;
   localparam int SUM_W   = 40;

   localparam int STEER_LIMIT = 100;

   typedef struct packed {
      logic [LEVEL_W-1:0] target_level;
      logic [DGAIN_W-1:0] deriv_gain;
   } gsps_cfg_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } gsps_status_type;

   // Kp, unsigned Q2.12; unused sets repeat set 0
   function automatic logic [GAIN_W-1:0] kp_lookup(input logic [KEY_W-1:0] idx);
      logic [GAIN_W-1:0] v;
      case (idx)
         3'd1:    v = 14'd6144;
         3'd2:    v = 14'd8192;
         3'd3:    v = 14'd6963;
         3'd4:    v = 14'd4915;
         default: v = 14'd11469;
      endcase
      return v;
   endfunction

   // 1/Ti, unsigned Q2.12; unused sets repeat set 0
   function automatic logic [GAIN_W-1:0] inv_ti_lookup(input logic [KEY_W-1:0] idx);
      logic [GAIN_W-1:0] v;
      case (idx)
         3'd1:    v = 14'd6966;
         3'd2:    v = 14'd6206;
         3'd3:    v = 14'd5596;
         3'd4:    v = 14'd5172;
         default: v = 14'd9225;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/gsps_sermul.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier: one multiplier bit per cycle, LSB first.
module gsps_sermul #(
   parameter int WA = 32,
   parameter int WB = 14
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [WA-1:0] mcand,
   input  wire logic [WB-1:0]        mplier,
   output logic                      done,
   output logic signed [WA+WB-1:0]   prod
);

   localparam int WP = WA + WB;
   localparam int CW = $clog2(WB + 1);

   logic signed [WP-1:0] acc_ff, acc_in;
   logic signed [WP-1:0] shift_ff, shift_in;
   logic [WB-1:0]        bits_ff, bits_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;

   always_comb begin
      acc_in   = acc_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         acc_in   = '0;
         shift_in = {{WB{mcand[WA-1]}}, mcand};
         bits_in  = mplier;
         cnt_in   = CW'(WB);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (bits_ff[0]) begin
            acc_in = acc_ff + shift_ff;
         end
         shift_in = shift_ff <<< 1;
         bits_in  = bits_ff >> 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff   <= acc_in;
      shift_ff <= shift_in;
      bits_ff  <= bits_in;
   end

   assign done = !busy_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

/* rtl/core/gsps_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Error, integral and derivative terms, then the PID sum and gain on
// three separate shift-add units.
module gsps_core #(
   parameter int GAIN_SETS = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gsps_pkg::gsps_cfg_type        cfg,
   input  wire logic                          in_valid,
   input  wire logic [gsps_pkg::LEVEL_W-1:0]  light_level,
   input  wire logic [gsps_pkg::SPEED_W-1:0]  speed,
   input  wire logic                          res_ready,
   output gsps_pkg::gsps_status_type          status,
   output logic [gsps_pkg::STEER_W-1:0]       steer
);
   import gsps_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TERM = 2'd1;
   localparam logic [1:0] ST_GAIN = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   localparam int P1_W = INTEG_W + GAIN_W;
   localparam int P2_W = DIF_W + DGAIN_W;
   localparam int P3_W = SUM_W + GAIN_W;
   localparam int Q3_W = P3_W - 28;

   logic [1:0] state_ff, state_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [STEER_W-1:0] last_err_ff, last_err_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic [KEY_W-1:0]          key_ff, key_in;

   logic                      accept, start_gain;
   logic signed [ERR_W-1:0]   err;
   logic signed [17:0]        err_step;
   logic signed [INTEG_W:0]   acc_wide;
   logic signed [INTEG_W-1:0] acc_sat;
   logic signed [DIF_W-1:0]   dif_raw, dif;
   logic [KEY_W-1:0]          key;

   logic                      done_i, done_d, done_k;
   logic signed [P1_W-1:0]    prod_i;
   logic signed [P2_W-1:0]    prod_d;
   logic signed [P3_W-1:0]    prod_k;
   logic signed [P1_W-13:0]   q_i;
   logic signed [SUM_W-1:0]   sum;
   logic signed [Q3_W-1:0]    q_k;

   assign accept     = (state_ff == ST_IDLE) && in_valid;
   assign start_gain = (state_ff == ST_TERM) && done_i && done_d;

   // Gain set from forward speed; out-of-range keys fall back to set 0
   always_comb begin
      key = '0;
      for (int k = 1; k < ROM_DEPTH; k++) begin
         if (int'($signed(speed)) >= KEY_BASE + KEY_STEP * k) begin
            key = KEY_W'(k);
         end
      end
      if (int'(key) >= GAIN_SETS) begin
         key = '0;
      end
   end

   always_comb begin
      err      = $signed({2'b00, cfg.target_level}) - $signed({2'b00, light_level});
      err_step = 18'(err) * 18'sd262;
      acc_wide = {integ_ff[INTEG_W-1], integ_ff} + (INTEG_W + 1)'(err_step);
      if (acc_wide[INTEG_W] != acc_wide[INTEG_W-1]) begin
         acc_sat = acc_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         acc_sat = acc_wide[INTEG_W-1:0];
      end
      dif_raw = DIF_W'(err) - DIF_W'(last_err_ff);
      dif     = dif_raw * 17'sd250;
   end

   gsps_sermul #(.WA(INTEG_W), .WB(GAIN_W)) u_mul_integ (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .mcand  (acc_sat),
      .mplier (inv_ti_lookup(key)),
      .done   (done_i),
      .prod   (prod_i)
   );

   gsps_sermul #(.WA(DIF_W), .WB(DGAIN_W)) u_mul_deriv (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .mcand  (dif),
      .mplier (cfg.deriv_gain),
      .done   (done_d),
      .prod   (prod_d)
   );

   // Integral term divided by 4096, truncated toward zero
   always_comb begin
      q_i = prod_i[P1_W-1:12];
      if (prod_i[P1_W-1] && (prod_i[11:0] != '0)) begin
         q_i = q_i + 1'b1;
      end
      sum = (SUM_W'(err_ff) <<< 16) + SUM_W'(q_i) + (SUM_W'(prod_d) <<< 4);
   end

   gsps_sermul #(.WA(SUM_W), .WB(GAIN_W)) u_mul_gain (
      .clock  (clock),
      .reset  (reset),
      .start  (start_gain),
      .mcand  (sum),
      .mplier (kp_lookup(key_ff)),
      .done   (done_k),
      .prod   (prod_k)
   );

   // Divide by 2^28 toward zero, negate, clamp
   always_comb begin
      q_k = prod_k[P3_W-1:28];
      if (prod_k[P3_W-1] && (prod_k[27:0] != '0)) begin
         q_k = q_k + 1'b1;
      end
      if (q_k >= Q3_W'(STEER_LIMIT)) begin
         steer = STEER_W'(-STEER_LIMIT);
      end else if (q_k <= -Q3_W'(STEER_LIMIT)) begin
         steer = STEER_W'(STEER_LIMIT);
      end else begin
         steer = STEER_W'(-q_k);
      end
   end

   always_comb begin
      state_in    = state_ff;
      integ_in    = integ_ff;
      last_err_in = last_err_ff;
      err_in      = err_ff;
      key_in      = key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               integ_in    = acc_sat;
               last_err_in = STEER_W'(err);
               err_in      = err;
               key_in      = key;
               state_in    = ST_TERM;
            end
         end
         ST_TERM: begin
            if (done_i && done_d) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            if (done_k) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         state_ff    <= state_in;
         integ_ff    <= integ_in;
         last_err_ff <= last_err_in;
      end
      err_ff <= err_in;
      key_ff <= key_in;
   end

   assign status.idle      = (state_ff == ST_IDLE);
   assign status.res_valid = (state_ff == ST_HOLD);

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !status.idle)
      else $error("core stayed idle after taking a sample");

   a_gain_after_terms: assert property (@(posedge clock) disable iff (reset)
      start_gain |-> (done_i && done_d))
      else $error("gain multiply started before the term products settled");

   a_result_settled: assert property (@(posedge clock) disable iff (reset)
      status.res_valid |-> done_k)
      else $error("result offered while the gain multiply is busy");

   a_taken_then_idle: assert property (@(posedge clock) disable iff (reset)
      (status.res_valid && res_ready) |=> status.idle)
      else $error("core did not return to idle after handing over a result");

endmodule

`default_nettype wire

/* rtl/core/gain_scheduled_pid_steering_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Gain-scheduled PID steering controller.
// req_ channel: one word per control tick, carrying a light sample and the
//    forward speed. The speed only picks one of the hardwired Kp/Ti sets.
// rsp_ channel: one steering word per request word, in order.
// csr_ channel: writes target_level (index 0) and deriv_gain (index 1);
//    always ready. Write only while no request is in flight.
// The term products (integral times 1/Ti, derivative times Td) run in
//    parallel on shift-add units at one bit per cycle; the Kp product
//    then runs on a third unit. One sample is in work at a time.
// The result sits in an output register, so a new request is taken while
//    the last steering word waits; a stalled receiver holds that word and,
//    once the next result is ready, holds off further requests.
// Reset clears the integral and previous error to zero, sets target_level
//    to 50 and deriv_gain to 0, and empties the output register.
module gain_scheduled_pid_steering_top #(
   parameter int GAIN_SETS = gsps_pkg::GAIN_SETS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // [6:0] light_level, [14:7] speed, [15] zero
   input  wire logic [gsps_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [7:0] steer
   output logic [gsps_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [gsps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [gsps_pkg::CSR_DATA_W-1:0]      csr_data
);
   import gsps_pkg::*;

   gsps_cfg_type              cfg_ff, cfg_in;
   gsps_status_type           status;
   logic                      res_ready;
   logic [STEER_W-1:0]        steer;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TARGET_LEVEL: cfg_in.target_level = csr_data[LEVEL_W-1:0];
            REG_DERIV_GAIN:   cfg_in.deriv_gain   = csr_data[DGAIN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   gsps_core #(.GAIN_SETS(GAIN_SETS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .light_level (req_tdata[LEVEL_W-1:0]),
      .speed       (req_tdata[LEVEL_W+SPEED_W-1:LEVEL_W]),
      .res_ready   (res_ready),
      .status      (status),
      .steer       (steer)
   );

   assign req_tready = status.idle;

   // Output register: load when empty or draining this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (status.res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = steer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_level <= TARGET_RESET;
         cfg_ff.deriv_gain   <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
